@@ rtl/core/hci_h4_receive_deframer_defines.svh @@
// Assertion macros for the HCI H4 receive deframer; of its modules, only hcirx_framer uses them.
// Needs nothing else; files that check their own logic include it.
`ifndef HCI_H4_RECEIVE_DEFRAMER_DEFINES_SVH
`define HCI_H4_RECEIVE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HCIRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HCIRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hcirx_pkg.sv @@
// Shared types and constants for the HCI H4 receive deframer.
// Used by hcirx_framer and hci_h4_receive_deframer; depends on nothing.
package hcirx_pkg;

	localparam logic [7:0] IND_EVENT = 8'h04;
	localparam logic [7:0] IND_ACL = 8'h02;
	localparam logic [7:0] SLEEP_CODE_RESET = 8'h30;

	// Header bytes after the indicator, counted from zero.
	localparam logic [1:0] EVENT_HDR_LAST = 2'd1;
	localparam logic [1:0] ACL_HDR_LEN_LO = 2'd2;
	localparam logic [1:0] ACL_HDR_LAST = 2'd3;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_ACL = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		kind_t packet_kind;
		logic packet_start;
		logic packet_end;
		logic sleep_request;
		logic bad_indicator;
	} result_t;

endpackage

@@ rtl/core/hcirx_framer.sv @@
// Packet framing state and per-byte classification logic.
// Depends on hcirx_pkg and the assertion macros header.
`include "hci_h4_receive_deframer_defines.svh"

module hcirx_framer (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [7:0] rx_byte,
	input logic [7:0] sleep_code,
	output hcirx_pkg::result_t result
);

	typedef enum logic [1:0] {
		ST_HUNT = 2'd0,
		ST_HEADER = 2'd1,
		ST_PAYLOAD = 2'd2
	} state_t;

	state_t state_q, state_d;
	logic is_acl_q, is_acl_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [1:0] hdr_idx_q, hdr_idx_d;
	logic [7:0] len_lo_q, len_lo_d;

	always_comb begin
		state_d = state_q;
		is_acl_d = is_acl_q;
		bytes_left_d = bytes_left_q;
		hdr_idx_d = hdr_idx_q;
		len_lo_d = len_lo_q;
		result.data_byte = rx_byte;
		result.packet_kind = hcirx_pkg::KIND_NONE;
		result.packet_start = 1'b0;
		result.packet_end = 1'b0;
		result.sleep_request = 1'b0;
		result.bad_indicator = 1'b0;

		unique case (state_q)
			ST_HEADER: begin
				result.packet_kind = is_acl_q ? hcirx_pkg::KIND_ACL : hcirx_pkg::KIND_EVENT;
				if (!is_acl_q) begin
					if (hdr_idx_q >= hcirx_pkg::EVENT_HDR_LAST) begin
						// Parameter length byte; zero closes the packet here.
						if (rx_byte == 8'd0) begin
							result.packet_end = 1'b1;
							state_d = ST_HUNT;
						end else begin
							bytes_left_d = {8'd0, rx_byte};
							state_d = ST_PAYLOAD;
						end
						hdr_idx_d = 2'd0;
					end else begin
						hdr_idx_d = hdr_idx_q + 2'd1;
					end
				end else begin
					if (hdr_idx_q == hcirx_pkg::ACL_HDR_LAST) begin
						if ({rx_byte, len_lo_q} == 16'd0) begin
							result.packet_end = 1'b1;
							state_d = ST_HUNT;
						end else begin
							bytes_left_d = {rx_byte, len_lo_q};
							state_d = ST_PAYLOAD;
						end
						hdr_idx_d = 2'd0;
					end else begin
						if (hdr_idx_q == hcirx_pkg::ACL_HDR_LEN_LO) begin
							len_lo_d = rx_byte;
						end
						hdr_idx_d = hdr_idx_q + 2'd1;
					end
				end
			end
			ST_PAYLOAD: begin
				result.packet_kind = is_acl_q ? hcirx_pkg::KIND_ACL : hcirx_pkg::KIND_EVENT;
				// The count is never zero here, since a zero length ends in the header.
				bytes_left_d = bytes_left_q - 16'd1;
				if (bytes_left_q == 16'd1) begin
					result.packet_end = 1'b1;
					state_d = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
				hdr_idx_d = 2'd0;
				if (rx_byte == hcirx_pkg::IND_EVENT) begin
					is_acl_d = 1'b0;
					result.packet_kind = hcirx_pkg::KIND_EVENT;
					result.packet_start = 1'b1;
					state_d = ST_HEADER;
				end else if (rx_byte == hcirx_pkg::IND_ACL) begin
					is_acl_d = 1'b1;
					result.packet_kind = hcirx_pkg::KIND_ACL;
					result.packet_start = 1'b1;
					state_d = ST_HEADER;
				end else if (rx_byte == sleep_code) begin
					result.sleep_request = 1'b1;
				end else begin
					result.bad_indicator = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			is_acl_q <= 1'b0;
			bytes_left_q <= 16'd0;
			hdr_idx_q <= 2'd0;
			len_lo_q <= 8'd0;
		end else if (advance) begin
			state_q <= state_d;
			is_acl_q <= is_acl_d;
			bytes_left_q <= bytes_left_d;
			hdr_idx_q <= hdr_idx_d;
			len_lo_q <= len_lo_d;
		end
	end

	`HCIRX_ASSERT_NOW(a_payload_count, clk, arst_n, state_q == ST_PAYLOAD,
		bytes_left_q != 16'd0, "payload phase with no bytes left")
	`HCIRX_ASSERT_NEXT(a_start_to_header, clk, arst_n, advance && result.packet_start,
		state_q == ST_HEADER && hdr_idx_q == 2'd0, "packet start did not enter header")
	`HCIRX_ASSERT_NEXT(a_end_to_hunt, clk, arst_n, advance && result.packet_end,
		state_q == ST_HUNT, "packet end did not return to hunting")

endmodule

@@ rtl/core/hci_h4_receive_deframer.sv @@
// Top level of the HCI H4 receive deframer: input stage, framer, result stage.
// Depends on hcirx_pkg and hcirx_framer.
//
// channel | handshake              | payload
// rx in   | in_valid / in_stall    | rx_byte
// result  | out_valid / out_stall  | data_byte, packet_kind, packet_start,
//         |                        | packet_end, sleep_request, bad_indicator
// config  | cfg_valid / cfg_ready  | sleep_indicator_code
//
// A byte accepted into the input register waits there until the result register is free;
// the framer then updates its state and the result register loads, raising out_valid.
// With no stall, one byte is accepted every cycle.
// A stalled result holds the result register; the input register then fills and in_stall rises.
// Reset clears the framing state and sets the sleep code to 0x30. Config is always ready.
module hci_h4_receive_deframer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] data_byte,
	output logic [1:0] packet_kind,
	output logic packet_start,
	output logic packet_end,
	output logic sleep_request,
	output logic bad_indicator,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] sleep_indicator_code
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	hcirx_pkg::result_t result_s2;
	hcirx_pkg::result_t result_comb;
	logic [7:0] sleep_code_q;
	logic s2_open;
	logic advance;

	assign s2_open = !valid_s2 || !out_stall;
	assign advance = valid_s1 && s2_open;
	assign in_stall = valid_s1 && !s2_open;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_code_q <= hcirx_pkg::SLEEP_CODE_RESET;
		end else if (cfg_valid) begin
			sleep_code_q <= sleep_indicator_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	hcirx_framer u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.rx_byte(byte_s1),
		.sleep_code(sleep_code_q),
		.result(result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid = valid_s2;
	assign data_byte = result_s2.data_byte;
	assign packet_kind = result_s2.packet_kind;
	assign packet_start = result_s2.packet_start;
	assign packet_end = result_s2.packet_end;
	assign sleep_request = result_s2.sleep_request;
	assign bad_indicator = result_s2.bad_indicator;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the HCI H4 receive deframer: directed and random byte streams
// are framed by a predictor in the testbench and compared with every result the block returns.
// Depends on hcirx_pkg and the hci_h4_receive_deframer RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [7:0] IND_COMMAND = 8'h01;
	localparam logic [7:0] IND_SYNC = 8'h03;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_ITEMS = 650;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEADER = 2'd1,
		PH_PAYLOAD = 2'd2
	} rx_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] data_byte;
	logic [1:0] packet_kind;
	logic packet_start;
	logic packet_end;
	logic sleep_request;
	logic bad_indicator;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] sleep_indicator_code = 8'h00;

	// Framing state mirrored by the predictor.
	rx_phase_t rx_phase = PH_HUNT;
	logic acl_open = 1'b0;
	logic [16:0] payload_left = '0;
	logic [2:0] hdr_count = '0;
	logic [7:0] acl_len_lo = '0;
	logic [7:0] sleep_code = hcirx_pkg::SLEEP_CODE_RESET;

	hcirx_pkg::result_t byte_reports[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	hci_h4_receive_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.packet_kind(packet_kind),
		.packet_start(packet_start),
		.packet_end(packet_end),
		.sleep_request(sleep_request),
		.bad_indicator(bad_indicator),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sleep_indicator_code(sleep_indicator_code)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic hcirx_pkg::result_t frame_rx_byte(input logic [7:0] b);
		hcirx_pkg::result_t r;
		logic [15:0] len;
		r = '0;
		r.data_byte = b;
		r.packet_kind = hcirx_pkg::KIND_NONE;
		case (rx_phase)
			PH_HEADER: begin
				r.packet_kind = acl_open ? hcirx_pkg::KIND_ACL : hcirx_pkg::KIND_EVENT;
				if (!acl_open) begin
					if (hdr_count >= 3'(hcirx_pkg::EVENT_HDR_LAST)) begin
						if (b == 8'h00) begin
							r.packet_end = 1'b1;
							rx_phase = PH_HUNT;
						end else begin
							payload_left = {9'd0, b};
							rx_phase = PH_PAYLOAD;
						end
						hdr_count = '0;
					end else begin
						hdr_count = hdr_count + 3'd1;
					end
				end else begin
					if (hdr_count >= 3'(hcirx_pkg::ACL_HDR_LAST)) begin
						len = {b, acl_len_lo};
						if (len == 16'd0) begin
							r.packet_end = 1'b1;
							rx_phase = PH_HUNT;
						end else begin
							payload_left = {1'b0, len};
							rx_phase = PH_PAYLOAD;
						end
						hdr_count = '0;
					end else begin
						if (hdr_count == 3'(hcirx_pkg::ACL_HDR_LEN_LO))
							acl_len_lo = b;
						hdr_count = hdr_count + 3'd1;
					end
				end
			end
			PH_PAYLOAD: begin
				r.packet_kind = acl_open ? hcirx_pkg::KIND_ACL : hcirx_pkg::KIND_EVENT;
				if (payload_left != '0)
					payload_left = payload_left - 17'd1;
				if (payload_left == '0) begin
					r.packet_end = 1'b1;
					rx_phase = PH_HUNT;
				end
			end
			default: begin
				// The packet codes win over a sleep code that happens to equal them.
				rx_phase = PH_HUNT;
				hdr_count = '0;
				if (b == hcirx_pkg::IND_EVENT) begin
					acl_open = 1'b0;
					r.packet_kind = hcirx_pkg::KIND_EVENT;
					r.packet_start = 1'b1;
					rx_phase = PH_HEADER;
				end else if (b == hcirx_pkg::IND_ACL) begin
					acl_open = 1'b1;
					r.packet_kind = hcirx_pkg::KIND_ACL;
					r.packet_start = 1'b1;
					rx_phase = PH_HEADER;
				end else if (b == sleep_code) begin
					r.sleep_request = 1'b1;
				end else begin
					r.bad_indicator = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		byte_reports.push_back(frame_rx_byte(b));
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (byte_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sleep_code(input logic [7:0] code);
		wait_drained();
		cfg_valid <= 1'b1;
		sleep_indicator_code <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sleep_code = code;
	endtask

	task automatic send_event(input logic [7:0] code, input logic [7:0] len);
		send_byte(hcirx_pkg::IND_EVENT);
		send_byte(code);
		send_byte(len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic send_acl(input logic [15:0] handle, input logic [15:0] len);
		send_byte(hcirx_pkg::IND_ACL);
		send_byte(handle[7:0]);
		send_byte(handle[15:8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_indicators();
		send_event(8'h00, 8'h00);
		send_byte(IND_COMMAND);
		send_byte(IND_SYNC);
		send_byte(hcirx_pkg::SLEEP_CODE_RESET);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	task automatic test_short_packets();
		send_acl(16'hFFFF, 16'h0000);
		send_acl(16'h0000, 16'h0001);
		send_event(8'hFF, 8'h01);
	endtask

	task automatic test_sleep_codes();
		write_sleep_code(hcirx_pkg::IND_EVENT);
		send_event(8'h0E, 8'h00);
		write_sleep_code(hcirx_pkg::IND_ACL);
		send_acl(16'h0123, 16'h0000);
		write_sleep_code(8'h00);
		send_byte(8'h00);
		write_sleep_code(8'hFF);
		send_byte(8'hFF);
		send_byte(hcirx_pkg::SLEEP_CODE_RESET);
		write_sleep_code(IND_COMMAND);
		send_byte(IND_COMMAND);
		send_byte(IND_SYNC);
	endtask

	// Mostly well-formed packets with short payloads, a few long ones, plus sleep bytes
	// and stray bytes that land wherever the framer happens to be.
	task automatic send_random_unit();
		int unsigned pick;
		int unsigned sel;
		logic [15:0] len;
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		if (pick < 8) begin
			send_byte(sleep_code);
		end else if (pick < 18) begin
			send_byte(8'($urandom_range(255)));
		end else if (pick < 60) begin
			len = (sel < 3) ? 16'd255 : (sel < 10) ? 16'($urandom_range(255))
				: 16'($urandom_range(12));
			send_event(8'($urandom_range(255)), len[7:0]);
		end else begin
			len = (sel < 3) ? 16'($urandom_range(300, 256)) : (sel < 10)
				? 16'($urandom_range(255)) : 16'($urandom_range(12));
			send_acl(16'($urandom_range(65535)), len);
		end
	endtask

	task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
		input logic [7:0] code);
		int unsigned target;
		write_sleep_code(code);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		target = bytes_sent + PHASE_ITEMS;
		while (bytes_sent < target)
			send_random_unit();
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name,
				exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		hcirx_pkg::result_t exp_r;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (byte_reports.size() == 0) begin
				$display("%0t: unexpected item: data_byte %0h with nothing outstanding",
					$realtime, data_byte);
				mismatches++;
			end else begin
				exp_r = byte_reports.pop_front();
				check_field("data_byte", exp_r.data_byte, data_byte);
				check_field("packet_kind", 8'(exp_r.packet_kind), 8'(packet_kind));
				check_field("packet_start", 8'(exp_r.packet_start), 8'(packet_start));
				check_field("packet_end", 8'(exp_r.packet_end), 8'(packet_end));
				check_field("sleep_request", 8'(exp_r.sleep_request), 8'(sleep_request));
				check_field("bad_indicator", 8'(exp_r.bad_indicator), 8'(bad_indicator));
			end
		end
	end

	// Watchdog: any channel moving an item resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 15;
		recv_idle_pct = 70;
		test_indicators();
		test_short_packets();
		test_sleep_codes();
		test_random_traffic(15, 70, hcirx_pkg::SLEEP_CODE_RESET);
		test_random_traffic(70, 15, 8'hFF);
		test_random_traffic(0, 0, 8'h00);
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && byte_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
